@@ rtl/csvt_pkg.sv @@
// Package for the CSV field tokenizer: scan modes, end codes, result and
// queue entry types, character and queue constants. No dependencies.
`default_nettype none
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_UNQ      = 3'd1,
    MODE_QUOTED   = 3'd2,
    MODE_QSEEN    = 3'd3,
    MODE_AFTER_CR = 3'd4
  } csvt_mode_t;

  typedef enum logic [1:0] {
    KIND_COMMA  = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_BUFEND = 2'd2,
    KIND_TEXT   = 2'd3
  } csvt_kind_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    logic        quoted;
    csvt_kind_t  kind;
    logic        ovf;
  } csvt_result_t;

  typedef struct packed {
    logic         two;
    csvt_result_t r0;
    csvt_result_t r1;
  } csvt_entry_t;

endpackage
`default_nettype wire

@@ rtl/csvt_if.sv @@
// Channel interfaces of the CSV field tokenizer: byte input and field output.
// Depends on nothing.
`default_nettype none
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface csvt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] field_start;
  logic [15:0] field_length;
  logic        was_quoted;
  logic [1:0]  end_kind;
  logic        overflow;
  logic        last_result;

  modport source (output valid, output field_start, output field_length,
                  output was_quoted, output end_kind, output overflow,
                  output last_result, input ready);
  modport sink (input valid, input field_start, input field_length,
                input was_quoted, input end_kind, input overflow,
                input last_result, output ready);
endinterface
`default_nettype wire

@@ rtl/csvt_scan.sv @@
// Front end: accepts bytes, runs the scan mode machine and builds one queue
// entry of up to two results per byte. Uses csvt_pkg and csvt_in_if.
`default_nettype none
module csvt_scan import csvt_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  csvt_in_if.sink    bytes,
  output csvt_entry_t push_entry,
  output logic       push_valid,
  input  wire logic  full
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS:0]   LEN_LIM = (POSITION_BITS+1)'(17'h0FFFF);

  csvt_mode_t               mode, mode_new;
  logic [POSITION_BITS-1:0] pos, ofs, s_new, p_inc, pm1, ce_start;
  logic                     ovf, ovf_eff, pmax, accept;
  logic                     is_quote, is_comma, is_lf, is_cr, is_term;
  logic                     open_quote, do_start;
  logic [POSITION_BITS:0]   p_plus, span_p, span_pm1, span_e, ce_len, fe_len;
  logic                     ce_valid, ce_quoted, fe_valid, fe_quoted;
  csvt_kind_t               ce_kind;
  csvt_result_t             r_case, r_flush;

  function automatic logic [15:0] clamp(input logic [POSITION_BITS:0] v);
    if (v > LEN_LIM) begin
      return 16'hFFFF;
    end
    return 16'(v);
  endfunction

  assign bytes.ready = !full && !rst;
  assign accept      = bytes.valid && bytes.ready;

  assign is_quote = (bytes.data_byte == CH_QUOTE);
  assign is_comma = (bytes.data_byte == CH_COMMA);
  assign is_lf    = (bytes.data_byte == CH_LF);
  assign is_cr    = (bytes.data_byte == CH_CR);
  assign is_term  = is_comma || is_lf || is_cr;

  assign pmax     = (pos == POS_MAX);
  assign p_inc    = pmax ? pos : pos + POSITION_BITS'(1);
  assign pm1      = (pos == '0) ? '0 : pos - POSITION_BITS'(1);
  assign p_plus   = {1'b0, pos} + (POSITION_BITS+1)'(1);
  assign span_p   = (pos > ofs) ? {1'b0, pos} - {1'b0, ofs} : '0;
  assign span_pm1 = (pm1 > ofs) ? {1'b0, pm1} - {1'b0, ofs} : '0;
  assign span_e   = (p_plus > {1'b0, s_new}) ? p_plus - {1'b0, s_new} : '0;

  always_comb begin
    mode_new   = mode;
    s_new      = ofs;
    open_quote = 1'b0;
    do_start   = 1'b0;
    ce_valid   = 1'b0;
    ce_start   = ofs;
    ce_len     = '0;
    ce_quoted  = 1'b0;
    ce_kind    = KIND_COMMA;
    case (mode)
      MODE_UNQ: begin
        if (is_term) begin
          ce_valid = 1'b1;
          ce_len   = span_p;
          if (is_comma) begin
            ce_kind  = KIND_COMMA;
            mode_new = MODE_START;
          end else if (is_lf) begin
            ce_kind  = KIND_LINE;
            mode_new = MODE_START;
          end else begin
            ce_kind  = KIND_LINE;
            mode_new = MODE_AFTER_CR;
          end
        end
      end
      MODE_QUOTED: begin
        if (is_quote) begin
          mode_new = MODE_QSEEN;
        end
      end
      MODE_QSEEN: begin
        if (is_quote) begin
          mode_new = MODE_QUOTED;
        end else begin
          ce_valid  = 1'b1;
          ce_len    = span_pm1;
          ce_quoted = 1'b1;
          if (is_comma) begin
            ce_kind  = KIND_COMMA;
            mode_new = MODE_START;
          end else if (is_lf) begin
            ce_kind  = KIND_LINE;
            mode_new = MODE_START;
          end else if (is_cr) begin
            ce_kind  = KIND_LINE;
            mode_new = MODE_AFTER_CR;
          end else begin
            ce_kind  = KIND_TEXT;
            do_start = 1'b1;
          end
        end
      end
      MODE_AFTER_CR: begin
        if (is_lf) begin
          mode_new = MODE_START;
        end else begin
          do_start = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    if (do_start) begin
      if (is_quote) begin
        open_quote = 1'b1;
        s_new      = p_inc;
        mode_new   = MODE_QUOTED;
      end else if (is_term) begin
        ce_valid  = 1'b1;
        ce_start  = pos;
        ce_len    = '0;
        ce_quoted = 1'b0;
        ce_kind   = is_comma ? KIND_COMMA : KIND_LINE;
        mode_new  = is_cr ? MODE_AFTER_CR : MODE_START;
      end else begin
        s_new    = pos;
        mode_new = MODE_UNQ;
      end
    end
  end

  assign ovf_eff   = ovf || (open_quote && pmax);
  assign fe_valid  = bytes.buffer_end &&
                     (mode_new == MODE_UNQ || mode_new == MODE_QUOTED ||
                      mode_new == MODE_QSEEN);
  assign fe_len    = (mode_new == MODE_QSEEN) ? span_p : span_e;
  assign fe_quoted = (mode_new != MODE_UNQ);

  always_comb begin
    r_case.start   = clamp({1'b0, ce_start});
    r_case.length  = clamp(ce_len);
    r_case.quoted  = ce_quoted;
    r_case.kind    = ce_kind;
    r_case.ovf     = ovf_eff;
    r_flush.start  = clamp({1'b0, s_new});
    r_flush.length = clamp(fe_len);
    r_flush.quoted = fe_quoted;
    r_flush.kind   = KIND_BUFEND;
    r_flush.ovf    = ovf_eff;
    push_entry.two = ce_valid && fe_valid;
    push_entry.r0  = ce_valid ? r_case : r_flush;
    push_entry.r1  = r_flush;
  end

  assign push_valid = accept && (ce_valid || fe_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START;
      pos  <= '0;
      ofs  <= '0;
      ovf  <= 1'b0;
    end else if (accept) begin
      if (bytes.buffer_end) begin
        mode <= MODE_START;
        pos  <= '0;
        ofs  <= '0;
        ovf  <= 1'b0;
      end else begin
        mode <= mode_new;
        pos  <= p_inc;
        ofs  <= s_new;
        ovf  <= ovf_eff || pmax;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/csvt_queue.sv @@
// Back end: short queue of result entries and the output beat sequencer that
// hands them out one result per beat. Uses csvt_pkg and csvt_out_if.
`default_nettype none
module csvt_queue import csvt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire csvt_entry_t push_entry,
  input  wire logic        push_valid,
  output logic             full,
  csvt_out_if.source       fields
);

  csvt_entry_t          q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp, rp;
  logic [QPTR_BITS:0]   count;
  logic                 sub, beat, pop;
  csvt_entry_t          head;
  csvt_result_t         cur;

  assign full = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign head = q[rp];
  assign cur  = sub ? head.r1 : head.r0;

  assign fields.valid        = (count != '0) && !rst;
  assign fields.field_start  = cur.start;
  assign fields.field_length = cur.length;
  assign fields.was_quoted   = cur.quoted;
  assign fields.end_kind     = cur.kind;
  assign fields.overflow     = cur.ovf;
  assign fields.last_result  = sub || !head.two;

  assign beat = fields.valid && fields.ready;
  assign pop  = beat && (sub || !head.two);

  always_ff @(posedge clk) begin
    if (push_valid) begin
      q[wp] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
      sub   <= 1'b0;
    end else begin
      if (push_valid) begin
        wp <= wp + QPTR_BITS'(1);
      end
      if (pop) begin
        rp  <= rp + QPTR_BITS'(1);
        sub <= 1'b0;
      end else if (beat) begin
        sub <= 1'b1;
      end
      case ({push_valid, pop})
        2'b10:   count <= count + (QPTR_BITS+1)'(1);
        2'b01:   count <= count - (QPTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/csv_field_tokenizer_core.sv @@
// CSV field tokenizer top level: scan front end feeding the result queue.
// Uses csvt_pkg, csvt_if, csvt_scan and csvt_queue.
//
// Usage: bytes carries one buffer byte per beat, buffer_end set on the final
// byte. fields carries one beat per CSV field: start position, raw length,
// quoted flag, end code, sticky overflow and last_result, which marks the
// final field caused by a byte. A byte causes zero, one or two fields.
// A field is registered in the queue before it shows on fields.
// Throughput: one byte per cycle while the queue is not full, set by the
// scan mode update; a byte causing two fields takes a beat for each of them.
// The queue holds four entries; when it is full, bytes.ready drops until the
// receiver takes the last beat of an entry, so a stalled receiver holds the
// current beat and backs up the input without loss.
// Reset: clears scan mode, position, field start and overflow, empties the
// queue; bytes.ready and fields.valid stay low while rst is high.
`default_nettype none
module csv_field_tokenizer_core import csvt_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  csvt_in_if.sink    bytes,
  csvt_out_if.source fields
);

  csvt_entry_t push_entry;
  logic        push_valid;
  logic        full;

  csvt_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .push_entry(push_entry),
    .push_valid(push_valid),
    .full      (full)
  );

  csvt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_entry(push_entry),
    .push_valid(push_valid),
    .full      (full),
    .fields    (fields)
  );

endmodule
`default_nettype wire

@@ rtl/csvt_checker.sv @@
// Port-level checks of the CSV field tokenizer, bound to the top level.
// Uses csvt_pkg.
`default_nettype none
module csvt_checker import csvt_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] field_start,
  input wire logic [15:0] field_length,
  input wire logic        was_quoted,
  input wire logic [1:0]  end_kind,
  input wire logic        overflow,
  input wire logic        last_result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(field_start) &&
    $stable(field_length) && $stable(was_quoted) && $stable(end_kind) &&
    $stable(overflow) && $stable(last_result))
    else $error("stalled field beat changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("field beat offered right after reset");

  a_bufend_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_kind == KIND_BUFEND |-> last_result)
    else $error("buffer end field not marked last");

  a_text_quoted: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_kind == KIND_TEXT |-> was_quoted)
    else $error("text after quote on an unquoted field");

endmodule

bind csv_field_tokenizer_core csvt_checker u_csvt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (fields.valid),
  .out_ready   (fields.ready),
  .field_start (fields.field_start),
  .field_length(fields.field_length),
  .was_quoted  (fields.was_quoted),
  .end_kind    (fields.end_kind),
  .overflow    (fields.overflow),
  .last_result (fields.last_result)
);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for csv_field_tokenizer_core: byte source, field sink and
// a field predictor with its own scan state. Needs csvt_pkg, csvt_if and the core.
module tb_top;
  import csvt_pkg::*;

  localparam int unsigned POS_BITS     = 16;
  localparam int unsigned POS_MAX      = (1 << POS_BITS) - 1;
  localparam int unsigned RANDOM_BYTES = 1900;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  typedef struct packed {
    csvt_result_t r;
    logic         last;
  } field_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  csvt_in_if  byte_ch();
  csvt_out_if field_ch();

  csv_field_tokenizer_core #(.POSITION_BITS(POS_BITS)) u_top (
    .clk(clk),
    .rst(rst),
    .bytes(byte_ch),
    .fields(field_ch)
  );

  always #1 clk = ~clk;

  byte_beat_t  byte_q[$];
  byte_beat_t  next_beat;
  field_rec_t  expected_fields[$];
  field_rec_t  step_fields[$];
  field_rec_t  want;
  int unsigned tx_gap;
  int unsigned rx_stall;
  bit          idle_tx = 1'b1;
  bit          idle_rx = 1'b1;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  csvt_mode_t  scan_mode   = MODE_START;
  int unsigned byte_pos    = 0;
  int unsigned field_begin = 0;
  bit          pos_ovf     = 1'b0;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int unsigned next_pos(int unsigned x);
    if (x >= POS_MAX) begin
      pos_ovf = 1'b1;
      return POS_MAX;
    end
    return x + 1;
  endfunction

  function automatic int unsigned run_len(int unsigned a, int unsigned b);
    return (b > a) ? b - a : 0;
  endfunction

  function automatic logic [15:0] clip16(int unsigned v);
    return (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void add_field(int unsigned start, int unsigned len, logic quoted,
                                    csvt_kind_t kind);
    field_rec_t f;
    f.r.start  = clip16(start);
    f.r.length = clip16(len);
    f.r.quoted = quoted;
    f.r.kind   = kind;
    f.r.ovf    = pos_ovf;
    f.last     = 1'b0;
    step_fields.push_back(f);
  endfunction

  function automatic void clear_scan();
    scan_mode   = MODE_START;
    byte_pos    = 0;
    field_begin = 0;
    pos_ovf     = 1'b0;
  endfunction

  function automatic void open_field(logic [7:0] b, int unsigned p);
    case (b)
      CH_QUOTE: begin
        field_begin = next_pos(p);
        scan_mode   = MODE_QUOTED;
      end
      CH_COMMA: begin
        add_field(p, 0, 1'b0, KIND_COMMA);
        scan_mode = MODE_START;
      end
      CH_LF: begin
        add_field(p, 0, 1'b0, KIND_LINE);
        scan_mode = MODE_START;
      end
      CH_CR: begin
        add_field(p, 0, 1'b0, KIND_LINE);
        scan_mode = MODE_AFTER_CR;
      end
      default: begin
        field_begin = p;
        scan_mode   = MODE_UNQ;
      end
    endcase
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic buf_end);
    int unsigned p;
    int unsigned s;
    int unsigned len;
    p = byte_pos;
    s = field_begin;
    step_fields.delete();
    case (scan_mode)
      MODE_UNQ: begin
        case (b)
          CH_COMMA: begin
            add_field(s, run_len(s, p), 1'b0, KIND_COMMA);
            scan_mode = MODE_START;
          end
          CH_LF: begin
            add_field(s, run_len(s, p), 1'b0, KIND_LINE);
            scan_mode = MODE_START;
          end
          CH_CR: begin
            add_field(s, run_len(s, p), 1'b0, KIND_LINE);
            scan_mode = MODE_AFTER_CR;
          end
          default: ;
        endcase
      end
      MODE_QUOTED: begin
        if (b == CH_QUOTE) scan_mode = MODE_QSEEN;
      end
      MODE_QSEEN: begin
        if (b == CH_QUOTE) begin
          scan_mode = MODE_QUOTED;
        end else begin
          len = run_len(s, (p > 0) ? p - 1 : 0);
          case (b)
            CH_COMMA: begin
              add_field(s, len, 1'b1, KIND_COMMA);
              scan_mode = MODE_START;
            end
            CH_LF: begin
              add_field(s, len, 1'b1, KIND_LINE);
              scan_mode = MODE_START;
            end
            CH_CR: begin
              add_field(s, len, 1'b1, KIND_LINE);
              scan_mode = MODE_AFTER_CR;
            end
            default: begin
              add_field(s, len, 1'b1, KIND_TEXT);
              open_field(b, p);
            end
          endcase
        end
      end
      MODE_AFTER_CR: begin
        if (b == CH_LF) scan_mode = MODE_START;
        else open_field(b, p);
      end
      default: open_field(b, p);
    endcase
    if (buf_end) begin
      s = field_begin;
      case (scan_mode)
        MODE_UNQ:    add_field(s, run_len(s, p + 1), 1'b0, KIND_BUFEND);
        MODE_QUOTED: add_field(s, run_len(s, p + 1), 1'b1, KIND_BUFEND);
        MODE_QSEEN:  add_field(s, run_len(s, p), 1'b1, KIND_BUFEND);
        default: ;
      endcase
    end
    if (step_fields.size() != 0) step_fields[$].last = 1'b1;
    foreach (step_fields[i]) expected_fields.push_back(step_fields[i]);
    if (buf_end) clear_scan();
    else byte_pos = next_pos(p);
  endfunction

  function automatic int field_diff(string what, int unsigned want_v, int unsigned got_v);
    if (want_v == got_v) return 0;
    $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
    return 1;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = $urandom_range(255);
    while (b == CH_QUOTE || b == CH_COMMA || b == CH_LF || b == CH_CR);
    return b;
  endfunction

  function automatic logic [7:0] any_byte();
    case ($urandom_range(7))
      0: return CH_QUOTE;
      1: return CH_COMMA;
      2: return CH_LF;
      3: return CH_CR;
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic push_byte(logic [7:0] b, logic buf_end);
    byte_q.push_back('{data: b, last: buf_end});
  endtask

  task automatic push_text(string s, logic buf_end);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], buf_end && (i == s.len() - 1));
  endtask

  task automatic queue_csv_buffer(int unsigned min_len, output int unsigned n);
    logic [7:0]  text[$];
    int unsigned k;
    while (text.size() < min_len || text.size() == 0) begin
      k = $urandom_range(9);
      if (k < 5) begin
        repeat ($urandom_range(6)) text.push_back(plain_byte());
      end else if (k < 9) begin
        text.push_back(CH_QUOTE);
        repeat ($urandom_range(6)) begin
          k = $urandom_range(9);
          if (k < 7) begin
            text.push_back(plain_byte());
          end else if (k == 7) begin
            text.push_back(CH_QUOTE);
            text.push_back(CH_QUOTE);
          end else begin
            text.push_back((k == 8) ? CH_COMMA : ($urandom_range(1) ? CH_LF : CH_CR));
          end
        end
        if ($urandom_range(9) != 0) text.push_back(CH_QUOTE);
      end else begin
        text.push_back(any_byte());
      end
      k = $urandom_range(9);
      if (k < 4) begin
        text.push_back(CH_COMMA);
      end else if (k == 4) begin
        text.push_back(CH_LF);
      end else if (k == 5) begin
        text.push_back(CH_CR);
      end else if (k < 8) begin
        text.push_back(CH_CR);
        text.push_back(CH_LF);
      end
    end
    if ($urandom_range(1)) repeat ($urandom_range(4, 1)) text.push_back(plain_byte());
    foreach (text[i]) push_byte(text[i], i == text.size() - 1);
    n = text.size();
  endtask

  task automatic queue_noise_buffer(output int unsigned n);
    n = $urandom_range(20, 1);
    for (int i = 0; i < n; i++) push_byte(any_byte(), i == n - 1);
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || byte_ch.valid || expected_fields.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (tx_gap != 0) begin
        byte_ch.valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (byte_q.size() != 0) begin
        next_beat = byte_q.pop_front();
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= next_beat.data;
        byte_ch.buffer_end <= next_beat.last;
        tx_gap <= idle_tx ? gap_len() : 0;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      field_ch.ready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall != 0) begin
      field_ch.ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      field_ch.ready <= 1'b1;
      if (idle_rx && $urandom_range(5) == 0) rx_stall <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
    end else begin
      if (byte_ch.valid && byte_ch.ready) tokenize_byte(byte_ch.data_byte, byte_ch.buffer_end);
      if (field_ch.valid && field_ch.ready) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: field beat with none expected, start %0d length %0d", $time,
                   field_ch.field_start, field_ch.field_length);
          mismatch_count++;
        end else begin
          want = expected_fields.pop_front();
          mismatch_count += field_diff("field_start", want.r.start, field_ch.field_start);
          mismatch_count += field_diff("field_length", want.r.length, field_ch.field_length);
          mismatch_count += field_diff("was_quoted", want.r.quoted, field_ch.was_quoted);
          mismatch_count += field_diff("end_kind", int'(want.r.kind), field_ch.end_kind);
          mismatch_count += field_diff("overflow", want.r.ovf, field_ch.overflow);
          mismatch_count += field_diff("last_result", want.last, field_ch.last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("csv_field_tokenizer_core verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    bit          paused;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.buffer_end = 1'b0;
    field_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_byte(8'h00, 1'b0);
    push_text(",\"a\"\"\"\015\n\"\",\n\015\"q\"z\015w", 1'b1);
    push_text("\"x\"y", 1'b1);
    push_text("\"", 1'b1);
    push_text("\"a", 1'b1);
    push_text("\"b\"", 1'b1);
    push_text("\377\n", 1'b1);
    wait_drained();

    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_BYTES) begin
      while (byte_q.size() > 16) @(negedge clk);
      if ($urandom_range(9) == 0) begin
        idle_tx = $urandom_range(1);
        idle_rx = $urandom_range(1);
      end
      if ($urandom_range(6) == 0) queue_noise_buffer(n);
      else queue_csv_buffer($urandom_range(40, 1), n);
      sent += n;
      if (!paused && sent >= RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    wait_drained();

    idle_tx = 1'b1;
    idle_rx = 1'b1;
    repeat (4) begin
      queue_csv_buffer($urandom_range(20, 1), n);
    end
    wait_drained();
    repeat (8) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("csv_field_tokenizer_core verification clean");
    end else begin
      $display("csv_field_tokenizer_core verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/csvt_pkg.sv
rtl/csvt_if.sv
rtl/csvt_scan.sv
rtl/csvt_queue.sv
rtl/csv_field_tokenizer_core.sv
rtl/csvt_checker.sv
tb/sv/tb_top.sv
